>>> src/movie_chunk_frame_decoder_core_assert.svh
// Assertion macros for the movie chunk frame decoder.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MOVIE_CHUNK_FRAME_DECODER_CORE_ASSERT_SVH
`define MOVIE_CHUNK_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define MCFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mcfd_pkg.sv
// Package for the movie chunk frame decoder: parse phases, result kinds,
// chunk types, register map and default parameters. No dependencies.
`default_nettype none

package mcfd_pkg;

  localparam int FRAME_BYTES_DEF   = 64000;
  localparam int ROW_PITCH_DEF     = 200;
  localparam int AUDIO_BLOCK_DEF   = 2205;
  localparam int AUDIO_BLOCKS_DEF  = 20;
  localparam int PALETTE_BYTES_DEF = 768;

  localparam int MAX_RESULTS = 4;
  localparam int AUDIO_RESET_BLOCK = 5;
  localparam logic [23:0] PTR_MAX = 24'hFF_FFFF;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_OVERSCAN = 1'b0;

  typedef enum logic [3:0] {
    PH_TYPE, PH_SIZE, PH_SKIPSIZE, PH_PAL, PH_PALX, PH_SND,
    PH_YLO, PH_YHI, PH_XOFF, PH_NPIX, PH_RUN
  } phase_e;

  typedef enum logic [1:0] {
    CT_PALETTE, CT_SOUND, CT_IMAGE, CT_DONE
  } chunk_e;

  typedef enum logic [2:0] {
    KIND_PAL, KIND_PIXEL, KIND_AUDIO, KIND_FRAME, KIND_END
  } kind_e;

endpackage

`default_nettype wire

>>> src/mcfd_in_if.sv
// Input byte channel of the movie chunk frame decoder.
// Standalone valid/ready interface, no dependencies.
`default_nettype none

interface mcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

`default_nettype wire

>>> src/mcfd_out_if.sv
// Result channel of the movie chunk frame decoder.
// Standalone valid/ready interface, no dependencies.
`default_nettype none

interface mcfd_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  kind;
  logic        [15:0] address;
  logic        [7:0]  byte_value;
  logic signed [15:0] sample;
  logic               out_of_range;
  logic               last;

  modport source (output valid, kind, address, byte_value, sample, out_of_range, last,
                  input ready);
  modport sink   (input valid, kind, address, byte_value, sample, out_of_range, last,
                  output ready);
endinterface

`default_nettype wire

>>> src/movie_chunk_frame_decoder_core.sv
// Movie chunk frame decoder top level: byte parser and result queue.
// Depends on mcfd_pkg, mcfd_in_if, mcfd_out_if and the assertion header.
// Results of an item are registered and appear in the cycle after it is accepted.
// Throughput: one item per cycle while the output register is empty or its last result
// is taken; an item with n results (n up to 4, only after a palette chunk) holds it until all n are taken.
// Reset: asynchronous, all parse state to its initial values, queue empty.
`default_nettype none

`include "movie_chunk_frame_decoder_core_assert.svh"

module movie_chunk_frame_decoder_core #(
  parameter int FRAME_BYTES   = mcfd_pkg::FRAME_BYTES_DEF,
  parameter int ROW_PITCH     = mcfd_pkg::ROW_PITCH_DEF,
  parameter int AUDIO_BLOCK   = mcfd_pkg::AUDIO_BLOCK_DEF,
  parameter int AUDIO_BLOCKS  = mcfd_pkg::AUDIO_BLOCKS_DEF,
  parameter int PALETTE_BYTES = mcfd_pkg::PALETTE_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  mcfd_in_if.sink                              in_ch,
  mcfd_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mcfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  localparam int PAL_W   = $clog2(PALETTE_BYTES + 1);
  localparam int APOS_W  = $clog2(AUDIO_BLOCK + 1);
  localparam int BLK_W   = $clog2(AUDIO_BLOCKS);
  localparam int RING_W  = $clog2(AUDIO_BLOCK * AUDIO_BLOCKS);
  localparam int PITCH_W = $clog2(ROW_PITCH + 1);
  localparam int PROD_W  = 16 + PITCH_W;
  localparam logic [BLK_W-1:0]  BLK_RST  = BLK_W'(mcfd_pkg::AUDIO_RESET_BLOCK % AUDIO_BLOCKS);
  localparam logic [RING_W-1:0] BASE_RST =
    RING_W'((mcfd_pkg::AUDIO_RESET_BLOCK % AUDIO_BLOCKS) * AUDIO_BLOCK);
  localparam logic [BLK_W-1:0]  BLK_LAST = BLK_W'(AUDIO_BLOCKS - 1);

  // parse state
  mcfd_pkg::phase_e   phase_q, phase_d;
  mcfd_pkg::chunk_e   ctype_q, ctype_d;
  logic [1:0]         hcnt_q, hcnt_d;
  logic [31:0]        left_q, left_d;
  logic [PAL_W-1:0]   pal_pos_q, pal_pos_d;
  logic [23:0]        ptr_q, ptr_d;
  logic [7:0]         run_q, run_d;
  logic [7:0]         ylo_q, ylo_d;
  logic [BLK_W-1:0]   ablk_q, ablk_d;
  logic [RING_W-1:0]  abase_q, abase_d;
  logic [APOS_W-1:0]  apos_q, apos_d;
  logic [7:0]         overscan_q;

  // result register
  logic               ov_q, ov_d;
  logic [2:0]         rem_q, rem_d;
  mcfd_pkg::kind_e    okind_q, okind_d;
  logic [15:0]        oaddr_q, oaddr_d;
  logic [7:0]         obyte_q, obyte_d;
  logic [15:0]        osmp_q, osmp_d;
  logic               ooor_q, ooor_d;

  // per-item result
  logic [2:0]         res_n;
  mcfd_pkg::kind_e    res_kind;
  logic [15:0]        res_addr;
  logic [7:0]         res_byte;
  logic [15:0]        res_smp;
  logic               res_oor;

  logic               accept;
  logic [7:0]         b;
  logic [31:0]        size_acc;
  logic [15:0]        y_off;
  logic [PROD_W-1:0]  y_prod;
  logic [24:0]        ptr_sum_b;
  logic [24:0]        ptr_sum_1;
  logic [31:0]        aaddr;
  logic [31:0]        left_m2;
  logic [31:0]        left_m1;
  logic [PAL_W-1:0]   pal_inc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mcfd_pkg::REG_OVERSCAN) ? 32'(overscan_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overscan_q <= 8'd0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == mcfd_pkg::REG_OVERSCAN) begin
      overscan_q <= pwdata[7:0];
    end
  end

  assign in_ch.ready = !ov_q || (out_ch.ready && rem_q == 3'd1);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  assign size_acc  = left_q | (32'(b) << {hcnt_q, 3'b000});
  assign y_off     = {b, ylo_q};
  assign y_prod    = PROD_W'(y_off) * PROD_W'(ROW_PITCH);
  assign ptr_sum_b = {1'b0, ptr_q} + 25'(b);
  assign ptr_sum_1 = {1'b0, ptr_q} + 25'd1;
  assign aaddr     = 32'(abase_q) + 32'(apos_q);
  assign left_m2   = left_q - 32'd2;
  assign left_m1   = left_q - 32'd1;
  assign pal_inc   = pal_pos_q + PAL_W'(1);

  always_comb begin
    phase_d   = phase_q;
    ctype_d   = ctype_q;
    hcnt_d    = hcnt_q;
    left_d    = left_q;
    pal_pos_d = pal_pos_q;
    ptr_d     = ptr_q;
    run_d     = run_q;
    ylo_d     = ylo_q;
    ablk_d    = ablk_q;
    abase_d   = abase_q;
    apos_d    = apos_q;
    res_n     = 3'd0;
    res_kind  = mcfd_pkg::KIND_END;
    res_addr  = 16'd0;
    res_byte  = 8'd0;
    res_smp   = 16'd0;
    res_oor   = 1'b0;

    if (in_ch.end_of_file) begin
      res_n   = 3'd1;
      phase_d = mcfd_pkg::PH_TYPE;
      hcnt_d  = 2'd0;
    end else begin
      unique case (phase_q)
        mcfd_pkg::PH_TYPE: begin
          hcnt_d = 2'd0;
          left_d = 32'd0;
          if (b >= 8'd1 && b <= 8'd4) begin
            ctype_d = mcfd_pkg::chunk_e'(2'(b - 8'd1));
            phase_d = mcfd_pkg::PH_SIZE;
          end else begin
            phase_d = mcfd_pkg::PH_SKIPSIZE;
          end
        end
        mcfd_pkg::PH_SIZE, mcfd_pkg::PH_SKIPSIZE: begin
          left_d = size_acc;
          if (hcnt_q != 2'd3) begin
            hcnt_d = hcnt_q + 2'd1;
          end else begin
            hcnt_d = 2'd0;
            if (phase_q == mcfd_pkg::PH_SKIPSIZE) begin
              phase_d = mcfd_pkg::PH_TYPE;
            end else begin
              unique case (ctype_q)
                mcfd_pkg::CT_PALETTE: begin
                  pal_pos_d = '0;
                  phase_d   = mcfd_pkg::PH_PAL;
                end
                mcfd_pkg::CT_SOUND: begin
                  apos_d = '0;
                  if (size_acc == 32'd0) begin
                    phase_d = mcfd_pkg::PH_TYPE;
                    ablk_d  = (ablk_q == BLK_LAST) ? '0 : ablk_q + BLK_W'(1);
                    abase_d = (ablk_q == BLK_LAST) ? '0 : abase_q + RING_W'(AUDIO_BLOCK);
                  end else begin
                    phase_d = mcfd_pkg::PH_SND;
                  end
                end
                mcfd_pkg::CT_IMAGE: begin
                  phase_d = (size_acc == 32'd0) ? mcfd_pkg::PH_TYPE : mcfd_pkg::PH_YLO;
                end
                mcfd_pkg::CT_DONE: begin
                  res_n    = 3'd1;
                  res_kind = mcfd_pkg::KIND_FRAME;
                  phase_d  = mcfd_pkg::PH_TYPE;
                end
              endcase
            end
          end
        end
        mcfd_pkg::PH_PAL: begin
          res_n     = 3'd1;
          res_kind  = mcfd_pkg::KIND_PAL;
          res_addr  = 16'(pal_pos_q);
          res_byte  = {b[5:0], 2'b00};
          pal_pos_d = pal_inc;
          if (32'(pal_inc) >= 32'(PALETTE_BYTES)) begin
            phase_d = mcfd_pkg::PH_PALX;
          end
        end
        mcfd_pkg::PH_PALX: begin
          res_n    = 3'(mcfd_pkg::MAX_RESULTS);
          res_kind = mcfd_pkg::KIND_PIXEL;
          res_byte = overscan_q;
          phase_d  = mcfd_pkg::PH_TYPE;
        end
        mcfd_pkg::PH_SND: begin
          if (32'(apos_q) < 32'(AUDIO_BLOCK)) begin
            res_n    = 3'd1;
            res_kind = mcfd_pkg::KIND_AUDIO;
            res_addr = aaddr[15:0];
            res_smp  = {~b[7], b[6:0], 8'h00};
            apos_d   = apos_q + APOS_W'(1);
          end
          left_d = left_m1;
          if (left_m1 == 32'd0) begin
            phase_d = mcfd_pkg::PH_TYPE;
            ablk_d  = (ablk_q == BLK_LAST) ? '0 : ablk_q + BLK_W'(1);
            abase_d = (ablk_q == BLK_LAST) ? '0 : abase_q + RING_W'(AUDIO_BLOCK);
          end
        end
        mcfd_pkg::PH_YLO: begin
          ylo_d   = b;
          phase_d = mcfd_pkg::PH_YHI;
        end
        mcfd_pkg::PH_YHI: begin
          ptr_d   = (32'(y_prod) > 32'(mcfd_pkg::PTR_MAX)) ? mcfd_pkg::PTR_MAX
                                                         : 24'(y_prod);
          left_d  = left_m2;
          phase_d = (left_m2 != 32'd0 && !left_m2[31]) ? mcfd_pkg::PH_XOFF
                                                     : mcfd_pkg::PH_TYPE;
        end
        mcfd_pkg::PH_XOFF: begin
          ptr_d   = ptr_sum_b[24] ? mcfd_pkg::PTR_MAX : ptr_sum_b[23:0];
          phase_d = mcfd_pkg::PH_NPIX;
        end
        mcfd_pkg::PH_NPIX: begin
          left_d = left_m2;
          run_d  = b;
          if (b == 8'd0) begin
            phase_d = (left_m2 != 32'd0 && !left_m2[31]) ? mcfd_pkg::PH_XOFF
                                                       : mcfd_pkg::PH_TYPE;
          end else begin
            phase_d = mcfd_pkg::PH_RUN;
          end
        end
        mcfd_pkg::PH_RUN: begin
          res_n    = 3'd1;
          res_kind = mcfd_pkg::KIND_PIXEL;
          res_addr = ptr_q[15:0];
          res_byte = b;
          res_oor  = (32'(ptr_q) >= 32'(FRAME_BYTES));
          ptr_d    = ptr_sum_1[24] ? mcfd_pkg::PTR_MAX : ptr_sum_1[23:0];
          left_d   = left_m1;
          run_d    = run_q - 8'd1;
          if (run_q == 8'd1) begin
            phase_d = (left_m1 != 32'd0 && !left_m1[31]) ? mcfd_pkg::PH_XOFF
                                                       : mcfd_pkg::PH_TYPE;
          end
        end
        default: begin
          phase_d = mcfd_pkg::PH_TYPE;
        end
      endcase
    end
  end

  // result register: an item with results loads it, otherwise each taken result steps it or empties it
  always_comb begin
    ov_d    = ov_q;
    rem_d   = rem_q;
    okind_d = okind_q;
    oaddr_d = oaddr_q;
    obyte_d = obyte_q;
    osmp_d  = osmp_q;
    ooor_d  = ooor_q;
    if (accept && res_n != 3'd0) begin
      ov_d    = 1'b1;
      rem_d   = res_n;
      okind_d = res_kind;
      oaddr_d = res_addr;
      obyte_d = res_byte;
      osmp_d  = res_smp;
      ooor_d  = res_oor;
    end else if (ov_q && out_ch.ready) begin
      rem_d   = rem_q - 3'd1;
      ov_d    = (rem_q != 3'd1);
      oaddr_d = oaddr_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mcfd_pkg::PH_TYPE;
      ctype_q   <= mcfd_pkg::CT_PALETTE;
      hcnt_q    <= 2'd0;
      left_q    <= 32'd0;
      pal_pos_q <= '0;
      ptr_q     <= 24'd0;
      run_q     <= 8'd0;
      ylo_q     <= 8'd0;
      ablk_q    <= BLK_RST;
      abase_q   <= BASE_RST;
      apos_q    <= '0;
      ov_q      <= 1'b0;
      rem_q     <= 3'd0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        ctype_q   <= ctype_d;
        hcnt_q    <= hcnt_d;
        left_q    <= left_d;
        pal_pos_q <= pal_pos_d;
        ptr_q     <= ptr_d;
        run_q     <= run_d;
        ylo_q     <= ylo_d;
        ablk_q    <= ablk_d;
        abase_q   <= abase_d;
        apos_q    <= apos_d;
      end
      ov_q  <= ov_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oaddr_q <= oaddr_d;
    obyte_q <= obyte_d;
    osmp_q  <= osmp_d;
    ooor_q  <= ooor_d;
  end

  assign out_ch.valid        = ov_q;
  assign out_ch.kind         = okind_q;
  assign out_ch.address      = oaddr_q;
  assign out_ch.byte_value   = obyte_q;
  assign out_ch.sample       = $signed(osmp_q);
  assign out_ch.out_of_range = ooor_q;
  assign out_ch.last         = (rem_q == 3'd1);

  `MCFD_ASSERT_IMPL(a_rem_matches_valid, 1'b1, ov_q == (rem_q != 3'd0),
                    "result count and valid disagree")
  `MCFD_ASSERT_IMPL(a_ready_on_drain, in_ch.ready && ov_q, out_ch.ready && rem_q == 3'd1,
                    "input taken while results still queued")
  `MCFD_ASSERT_IMPL(a_single_end, ov_q && okind_q == mcfd_pkg::KIND_END, rem_q == 3'd1,
                    "end of stream not a single result")
  `MCFD_ASSERT_IMPL(a_block_range, 1'b1, 32'(ablk_q) < 32'(AUDIO_BLOCKS),
                    "audio block out of ring")
  `MCFD_ASSERT_NEXT(a_multi_step, ov_q && out_ch.ready && rem_q > 3'd1,
                    ov_q && rem_q == $past(rem_q) - 3'd1,
                    "multi-result item did not step")

endmodule

`default_nettype wire

>>> bench/mcfd_result_checker.sv
// Checker for the movie chunk frame decoder: tracks the parser state from the
// accepted input bytes and config writes, and compares every result item.
// Depends on mcfd_pkg, mcfd_in_if and mcfd_out_if.
module mcfd_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcfd_in_if                              in_ch,
  mcfd_out_if                             out_ch,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [mcfd_pkg::CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic [31:0]                     prdata_i,
  input  logic                            pready_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mcfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] OVERSCAN_ADDR = CFG_ADDR_W'(4 * REG_OVERSCAN);

  typedef struct packed {
    kind_e              kind;
    logic        [15:0] address;
    logic        [7:0]  byte_value;
    logic signed [15:0] sample;
    logic               out_of_range;
    logic               last;
  } decoder_write_t;

  phase_e      parse_q;
  chunk_e      chunk_q;
  logic [1:0]  hdr_cnt;
  logic [31:0] bytes_left;
  int unsigned pal_pos;
  logic [23:0] pix_ptr;
  logic [7:0]  run_left;
  logic [7:0]  y_lo;
  int unsigned ring_block;
  int unsigned ring_pos;
  logic [7:0]  overscan;

  decoder_write_t expected_writes[$];
  decoder_write_t want;
  int fails = 0;
  int npend = 0;

  assign fail_count_o = fails;
  assign pending_o    = npend;

  function automatic decoder_write_t make_write(kind_e k, logic [15:0] a, logic [7:0] v,
                                                logic [15:0] s, logic oor);
    decoder_write_t w;
    w.kind         = k;
    w.address      = a;
    w.byte_value   = v;
    w.sample       = s;
    w.out_of_range = oor;
    w.last         = 1'b0;
    return w;
  endfunction

  function automatic logic [23:0] sat_add(logic [23:0] p, logic [31:0] amt);
    logic [32:0] s;
    s = {9'b0, p} + {1'b0, amt};
    return (s > {9'b0, PTR_MAX}) ? PTR_MAX : s[23:0];
  endfunction

  // next pair while the signed count is still positive
  function automatic phase_e pair_done(logic [31:0] left);
    return (left != 0 && !left[31]) ? PH_XOFF : PH_TYPE;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, exp_val);
    fails++;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    decoder_write_t res[$];
    logic [7:0]  t;
    logic [15:0] y;
    logic [31:0] ring_addr;
    res = {};
    if (eof) begin
      res.push_back(make_write(KIND_END, 16'd0, 8'd0, 16'd0, 1'b0));
      parse_q = PH_TYPE;
      hdr_cnt = 2'd0;
    end else begin
      case (parse_q)
        PH_TYPE: begin
          t = b - 8'd1;
          hdr_cnt = 2'd0;
          bytes_left = 32'd0;
          if (t <= 8'd3) begin
            chunk_q = chunk_e'(t[1:0]);
            parse_q = PH_SIZE;
          end else begin
            parse_q = PH_SKIPSIZE;
          end
        end
        PH_SIZE, PH_SKIPSIZE: begin
          bytes_left |= 32'(b) << (8 * hdr_cnt);
          if (hdr_cnt < 2'd3) begin
            hdr_cnt++;
          end else begin
            hdr_cnt = 2'd0;
            if (parse_q == PH_SKIPSIZE) begin
              parse_q = PH_TYPE;
            end else begin
              case (chunk_q)
                CT_PALETTE: begin
                  pal_pos = 0;
                  parse_q = PH_PAL;
                end
                CT_SOUND: begin
                  ring_pos = 0;
                  if (bytes_left == 0) begin
                    ring_block = (ring_block + 1) % AUDIO_BLOCKS_DEF;
                    parse_q = PH_TYPE;
                  end else begin
                    parse_q = PH_SND;
                  end
                end
                CT_IMAGE: parse_q = (bytes_left == 0) ? PH_TYPE : PH_YLO;
                default: begin
                  res.push_back(make_write(KIND_FRAME, 16'd0, 8'd0, 16'd0, 1'b0));
                  parse_q = PH_TYPE;
                end
              endcase
            end
          end
        end
        PH_PAL: begin
          res.push_back(make_write(KIND_PAL, 16'(pal_pos), {b[5:0], 2'b00}, 16'd0, 1'b0));
          pal_pos++;
          if (pal_pos >= PALETTE_BYTES_DEF) parse_q = PH_PALX;
        end
        PH_PALX: begin
          for (int i = 0; i < 4; i++)
            res.push_back(make_write(KIND_PIXEL, 16'(i), overscan, 16'd0, 1'b0));
          parse_q = PH_TYPE;
        end
        PH_SND: begin
          if (ring_pos < AUDIO_BLOCK_DEF) begin
            ring_addr = ring_block * AUDIO_BLOCK_DEF + ring_pos;
            res.push_back(make_write(KIND_AUDIO, ring_addr[15:0], 8'd0,
                                     {b ^ 8'h80, 8'h00}, 1'b0));
            ring_pos++;
          end
          bytes_left--;
          if (bytes_left == 0) begin
            ring_block = (ring_block + 1) % AUDIO_BLOCKS_DEF;
            parse_q = PH_TYPE;
          end
        end
        PH_YLO: begin
          y_lo = b;
          parse_q = PH_YHI;
        end
        PH_YHI: begin
          y = {b, y_lo};
          pix_ptr = sat_add(24'd0, y * ROW_PITCH_DEF);
          bytes_left -= 32'd2;
          parse_q = pair_done(bytes_left);
        end
        PH_XOFF: begin
          pix_ptr = sat_add(pix_ptr, 32'(b));
          parse_q = PH_NPIX;
        end
        PH_NPIX: begin
          bytes_left -= 32'd2;
          run_left = b;
          parse_q = (b == 8'd0) ? pair_done(bytes_left) : PH_RUN;
        end
        PH_RUN: begin
          res.push_back(make_write(KIND_PIXEL, pix_ptr[15:0], b, 16'd0,
                                   pix_ptr >= FRAME_BYTES_DEF));
          pix_ptr = sat_add(pix_ptr, 32'd1);
          bytes_left--;
          run_left--;
          if (run_left == 8'd0) parse_q = pair_done(bytes_left);
        end
        default: parse_q = PH_TYPE;
      endcase
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_writes.push_back(res[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q    <= PH_TYPE;
      chunk_q    <= CT_PALETTE;
      hdr_cnt    <= 2'd0;
      bytes_left <= 32'd0;
      pal_pos    <= 0;
      pix_ptr    <= 24'd0;
      run_left   <= 8'd0;
      y_lo       <= 8'd0;
      ring_block <= AUDIO_RESET_BLOCK % AUDIO_BLOCKS_DEF;
      ring_pos   <= 0;
      overscan   <= 8'd0;
      expected_writes.delete();
      npend      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("result with nothing expected, kind", 32'(out_ch.kind), 32'd0);
        end else begin
          want = expected_writes.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch("kind", 32'(out_ch.kind), 32'(want.kind));
          if (out_ch.address !== want.address)
            report_mismatch("address", 32'(out_ch.address), 32'(want.address));
          if (out_ch.byte_value !== want.byte_value)
            report_mismatch("byte_value", 32'(out_ch.byte_value), 32'(want.byte_value));
          if (out_ch.sample !== want.sample)
            report_mismatch("sample", 32'(out_ch.sample), 32'(want.sample));
          if (out_ch.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", 32'(out_ch.out_of_range),
                            32'(want.out_of_range));
          if (out_ch.last !== want.last)
            report_mismatch("last", 32'(out_ch.last), 32'(want.last));
        end
      end
      if (psel_i && penable_i && pready_i && paddr_i == OVERSCAN_ADDR) begin
        if (pwrite_i) overscan = pwdata_i[7:0];
        else if (prdata_i !== {24'd0, overscan})
          report_mismatch("overscan readback", prdata_i, {24'd0, overscan});
      end
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.end_of_file);
      npend <= expected_writes.size();
    end
  end

endmodule

>>> bench/tb_movie_chunk_frame_decoder_core.sv
// Testbench top for movie_chunk_frame_decoder_core: builds chunked byte
// streams under several idle and stall patterns and gives the verdict.
// Depends on mcfd_pkg, mcfd_in_if, mcfd_out_if and mcfd_result_checker.
module tb_movie_chunk_frame_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mcfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] OVERSCAN_ADDR = CFG_ADDR_W'(4 * REG_OVERSCAN);
  localparam int LONG_HOLD = 300;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int writes_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_done      = 0;
  int items_sent     = 0;
  logic [7:0] image_body[$];

  mcfd_in_if  in_ch();
  mcfd_out_if out_ch();

  movie_chunk_frame_decoder_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mcfd_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (writes_pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("tb_movie_chunk_frame_decoder_core NOT OK");
    $finish;
  end

  // result receiver, with one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_done++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_header(input logic [7:0] type_byte, input logic [31:0] size);
    push_item(type_byte, 1'b0);
    for (int i = 0; i < 4; i++) push_item(size[8*i +: 8], 1'b0);
  endtask

  task automatic send_sound(input int n);
    send_header(8'd2, 32'(n));
    repeat (n) push_item(8'($urandom), 1'b0);
  endtask

  task automatic send_palette(input logic full);
    send_header(8'd1, $urandom());
    if (full) begin
      repeat (PALETTE_BYTES_DEF + 1) push_item(8'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(6)) push_item(8'($urandom), 1'b0);
      push_item(8'($urandom), 1'b1);
    end
  endtask

  task automatic add_pair(input logic [7:0] x, input int n, inout int count);
    image_body.push_back(x);
    image_body.push_back(8'(n));
    repeat (n) image_body.push_back(8'($urandom));
    count += 2 + n;
  endtask

  task automatic send_image(input logic [31:0] size, input logic [15:0] y);
    send_header(8'd3, size);
    push_item(y[7:0], 1'b0);
    push_item(y[15:8], 1'b0);
    foreach (image_body[i]) push_item(image_body[i], 1'b0);
    image_body.delete();
  endtask

  task automatic send_random_image();
    int count;
    int r;
    logic [15:0] y;
    logic [31:0] size;
    count = 2;
    repeat ($urandom_range(1, 4))
      add_pair(8'($urandom), ($urandom_range(19) == 0) ? 255 : $urandom_range(6), count);
    r = $urandom_range(9);
    if (r < 7) y = 16'($urandom_range(319));
    else if (r < 9) y = 16'($urandom_range(320, 330));
    else y = 16'($urandom);
    r = $urandom_range(9);
    if (r < 7) size = 32'(count);
    else if (r == 7) size = 32'($urandom_range(1, count));
    else if (r == 8) size = 32'(count + $urandom_range(1, 4));
    else size = {1'b1, 31'($urandom)};
    send_image(size, y);
  endtask

  task automatic send_random_traffic(input int n_items);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_random_image();
      end else if (r < 50) begin
        send_sound($urandom_range(8));
      end else if (r < 58) begin
        send_header(8'd4, $urandom());
      end else if (r < 66) begin
        send_header($urandom_range(1) ? 8'd0 : 8'($urandom_range(5, 255)), $urandom());
      end else if (r < 74) begin
        push_item(8'($urandom), 1'b1);
      end else if (r < 84) begin
        repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0);
        push_item(8'($urandom), 1'b1);
      end else if (r < 92) begin
        send_palette(1'b0);
      end else begin
        push_item(8'($urandom_range(1, 4)), 1'b0);
        repeat ($urandom_range(3)) push_item(8'($urandom), 1'b0);
        push_item(8'($urandom), 1'b1);
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (writes_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int count;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'd0;
    in_ch.end_of_file = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = 32'd0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: done chunk, wrapped type byte, empty image, broken header,
    // sound extremes
    send_header(8'd4, 32'hFFFF_FFFF);
    send_header(8'd0, 32'h0000_0000);
    send_header(8'd3, 32'h0000_0000);
    push_item(8'd3, 1'b0);
    push_item(8'hFF, 1'b1);
    send_header(8'd2, 32'd2);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      cfg_access(1'b1, OVERSCAN_ADDR,
                 (ph == 0) ? 32'hFF : (ph == 1) ? 32'h0 : 32'($urandom_range(1, 254)));
      cfg_access(1'b0, OVERSCAN_ADDR, 32'd0);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 0) hold_req++;
      send_palette(1'b1);
      if (ph == 0) begin
        // oversized sound chunk, then enough chunks to wrap the ring
        send_sound(AUDIO_BLOCK_DEF + 5);
        repeat (AUDIO_BLOCKS_DEF) send_sound(1);
        // run crossing the frame end
        count = 2;
        add_pair(8'd199, 3, count);
        send_image(32'(count), 16'd319);
        // run outlasting the count
        count = 2;
        add_pair(8'd1, 5, count);
        send_image(32'd4, 16'd17);
        // negative count once the row offset is taken
        send_image(32'h8000_0002, 16'($urandom));
        // drive the pointer into saturation with empty runs
        repeat (14400) add_pair(8'd255, 0, count);
        add_pair(8'd0, 2, count);
        send_image(32'h7FFF_FFFF, 16'hFFFF);
        push_item(8'($urandom), 1'b1);
      end
      send_random_traffic(55);
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_movie_chunk_frame_decoder_core OK");
    end else begin
      $display("tb_movie_chunk_frame_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
